// ----- hdl/sab_pkg.sv -----
// Shared constants and codes for the suffix automaton builder
`default_nettype none
package sab_pkg;
	localparam int MAX_TEXT_DEF  = 1024;
	localparam int ALPHABET_DEF  = 26;
	localparam int EPOCH_W       = 4;
	localparam int KIND_W        = 2;
	localparam int SYM_W         = 5;
	localparam int STATE_W       = 11;
	localparam int STATUS_W      = 2;

	localparam logic [KIND_W-1:0] KIND_EXTEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
endpackage
`default_nettype wire

// ----- hdl/suffix_automaton_builder_core.sv -----
// Suffix automaton builder: sequencer over the transition and node stores
//  channel | direction | words
//  in      | sink      | kind, symbol, state_index
//  out     | source    | next_state, found, state_count, text_length, status
// Query reads one transition entry. Extend walks the suffix links, checks the length
// when the walk finds an existing transition, and on a clone copies the row letter by
// letter, redirects the visited states and writes the links.
// Clear and rejected items are answered from idle. Reset, and every 2**EPOCH_W-th clear,
// start a clearing pass over the whole transition store with in_ready low.
// A stalled out word holds the sequencer in its final step.
`default_nettype none
module suffix_automaton_builder_core #(
	parameter int MAX_TEXT      = sab_pkg::MAX_TEXT_DEF,
	parameter int ALPHABET_SIZE = sab_pkg::ALPHABET_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [sab_pkg::KIND_W-1:0]   kind,
	input  wire logic [sab_pkg::SYM_W-1:0]    symbol,
	input  wire logic [sab_pkg::STATE_W-1:0]  state_index,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [sab_pkg::STATE_W-1:0]       next_state,
	output logic                              found,
	output logic [sab_pkg::STATE_W-1:0]       state_count,
	output logic [sab_pkg::STATE_W-1:0]       text_length,
	output logic [sab_pkg::STATUS_W-1:0]      status
);
	localparam int MAX_STATES = 2 * MAX_TEXT;
	localparam int SW         = $clog2(MAX_STATES);
	localparam int TW         = $clog2(MAX_STATES + 1);
	localparam int NW         = $clog2(MAX_TEXT + 1);
	localparam int TDEPTH     = MAX_STATES * ALPHABET_SIZE;
	localparam int TAW        = $clog2(TDEPTH);
	localparam int CW         = $clog2(ALPHABET_SIZE);
	localparam int XW         = $clog2(ALPHABET_SIZE);

	typedef enum logic [16:0] {
		ST_IDLE   = 17'b00000000000000001,
		ST_CLR    = 17'b00000000000000010,
		ST_E0     = 17'b00000000000000100,
		ST_E1     = 17'b00000000000001000,
		ST_W_RD   = 17'b00000000000010000,
		ST_W_EV   = 17'b00000000000100000,
		ST_CHK_RD = 17'b00000000001000000,
		ST_CHK    = 17'b00000000010000000,
		ST_CP_RD  = 17'b00000000100000000,
		ST_CP_WR  = 17'b00000001000000000,
		ST_RED_RD = 17'b00000010000000000,
		ST_RED_EV = 17'b00000100000000000,
		ST_FIN_L  = 17'b00001000000000000,
		ST_FIN_Y  = 17'b00010000000000000,
		ST_Q_RD   = 17'b00100000000000000,
		ST_Q_EV   = 17'b01000000000000000,
		ST_DONE   = 17'b10000000000000000
	} seq_state_t;

	seq_state_t                    st_q;
	logic [sab_pkg::EPOCH_W-1:0]   epoch_q;
	logic [TAW-1:0]                clr_q;
	logic [SW-1:0]                 last_q;
	logic [TW-1:0]                 total_q;
	logic [NW-1:0]                 appended_q;
	logic [SW-1:0]                 p_q;
	logic [SW-1:0]                 y_q;
	logic [SW-1:0]                 q_q;
	logic [SW-1:0]                 k_q;
	logic [SW-1:0]                 lenp_q;
	logic [XW-1:0]                 x_q;
	logic [CW-1:0]                 c_q;
	logic                          is_query_q;
	logic                          qfound_q;
	logic [SW-1:0]                 qnext_q;

	logic                          out_valid_q;
	logic [sab_pkg::STATE_W-1:0]   next_q;
	logic                          found_q;
	logic [sab_pkg::STATE_W-1:0]   count_q;
	logic [sab_pkg::STATE_W-1:0]   length_q;
	logic [sab_pkg::STATUS_W-1:0]  status_q;

	logic                          t_rd_valid;
	logic [SW-1:0]                 t_rd_target;
	logic [TAW-1:0]                t_rd_addr;
	logic                          t_we;
	logic [TAW-1:0]                t_wa;
	logic                          t_wvalid;
	logic [SW-1:0]                 t_wtarget;
	logic [SW-1:0]                 link_rd;
	logic [SW-1:0]                 len_rd;
	logic [SW-1:0]                 link_ra;
	logic [SW-1:0]                 len_ra;
	logic                          link_we;
	logic [SW-1:0]                 link_wa;
	logic [SW-1:0]                 link_wd;
	logic                          len_we;
	logic [SW-1:0]                 len_wa;
	logic [SW-1:0]                 len_wd;
	logic                          out_free;
	logic                          accept;
	logic                          sym_ok;
	logic                          idx_ok;

	function automatic logic [TAW-1:0] row_addr(input logic [SW-1:0] s,
			input logic [CW-1:0] col);
		row_addr = TAW'(s) * TAW'(ALPHABET_SIZE) + TAW'(col);
	endfunction

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (st_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign sym_ok   = 32'(symbol) < ALPHABET_SIZE;
	assign idx_ok   = 32'(state_index) < 32'(total_q);

	always_comb begin
		t_rd_addr = row_addr(p_q, CW'(x_q));
		if (st_q == ST_CP_RD) begin
			t_rd_addr = row_addr(q_q, c_q);
		end
		t_we      = 1'b0;
		t_wa      = row_addr(p_q, CW'(x_q));
		t_wvalid  = 1'b1;
		t_wtarget = y_q;
		link_ra   = p_q;
		len_ra    = p_q;
		link_we   = 1'b0;
		link_wa   = y_q;
		link_wd   = k_q;
		len_we    = 1'b0;
		len_wa    = y_q;
		len_wd    = len_rd + SW'(1);
		unique case (st_q)
			ST_CLR: begin
				t_we     = 1'b1;
				t_wa     = clr_q;
				t_wvalid = 1'b0;
			end
			ST_E0: begin
				len_ra = last_q;
			end
			ST_E1: begin
				len_we = 1'b1;
			end
			ST_W_EV: begin
				if (!t_rd_valid) begin
					t_we = 1'b1;
					if (p_q == '0) begin
						link_we = 1'b1;
						link_wd = '0;
					end
				end
			end
			ST_CHK_RD: begin
				link_ra = q_q;
				len_ra  = q_q;
			end
			ST_CHK: begin
				link_we = 1'b1;
				if (lenp_q + SW'(1) == len_rd) begin
					link_wd = q_q;
				end else begin
					link_wa = SW'(total_q);
					link_wd = link_rd;
					len_we  = 1'b1;
					len_wa  = SW'(total_q);
					len_wd  = lenp_q + SW'(1);
				end
			end
			ST_CP_WR: begin
				t_we      = 1'b1;
				t_wa      = row_addr(k_q, c_q);
				t_wvalid  = t_rd_valid;
				t_wtarget = t_rd_target;
			end
			ST_RED_EV: begin
				if (t_rd_valid && t_rd_target == q_q) begin
					t_we      = 1'b1;
					t_wtarget = k_q;
				end
			end
			ST_FIN_L: begin
				link_we = 1'b1;
				link_wa = q_q;
			end
			ST_FIN_Y: begin
				link_we = 1'b1;
			end
			ST_Q_RD: ;
			default: ;
		endcase
	end

	sab_trans_mem #(.DEPTH(TDEPTH), .AW(TAW), .SW(SW)) u_trans (
		.clk       (clk),
		.epoch     (epoch_q),
		.rd_addr   (t_rd_addr),
		.rd_valid  (t_rd_valid),
		.rd_target (t_rd_target),
		.wr_en     (t_we),
		.wr_addr   (t_wa),
		.wr_valid  (t_wvalid),
		.wr_target (t_wtarget)
	);

	sab_node_mem #(.DEPTH(MAX_STATES), .SW(SW)) u_node (
		.clk          (clk),
		.link_rd_addr (link_ra),
		.link_rd_data (link_rd),
		.link_we      (link_we),
		.link_wa      (link_wa),
		.link_wd      (link_wd),
		.len_rd_addr  (len_ra),
		.len_rd_data  (len_rd),
		.len_we       (len_we),
		.len_wa       (len_wa),
		.len_wd       (len_wd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			epoch_q     <= '0;
			clr_q       <= '0;
			last_q      <= '0;
			total_q     <= TW'(1);
			appended_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						p_q        <= last_q;
						y_q        <= SW'(total_q);
						x_q        <= XW'(symbol);
						is_query_q <= 1'b0;
						next_q     <= '0;
						found_q    <= 1'b0;
						count_q    <= sab_pkg::STATE_W'(total_q);
						length_q   <= sab_pkg::STATE_W'(appended_q);
						status_q   <= sab_pkg::STATUS_OK;
						case (kind)
							sab_pkg::KIND_EXTEND: begin
								next_q <= sab_pkg::STATE_W'(last_q);
								if (!sym_ok) begin
									status_q    <= sab_pkg::STATUS_RANGE;
									out_valid_q <= 1'b1;
								end else if (32'(appended_q) >= MAX_TEXT) begin
									status_q    <= sab_pkg::STATUS_FULL;
									out_valid_q <= 1'b1;
								end else begin
									st_q <= ST_E0;
								end
							end
							sab_pkg::KIND_QUERY: begin
								if (!sym_ok || !idx_ok) begin
									status_q    <= sab_pkg::STATUS_RANGE;
									out_valid_q <= 1'b1;
								end else begin
									p_q        <= SW'(state_index);
									is_query_q <= 1'b1;
									st_q       <= ST_Q_RD;
								end
							end
							sab_pkg::KIND_CLEAR: begin
								last_q      <= '0;
								total_q     <= TW'(1);
								appended_q  <= '0;
								count_q     <= sab_pkg::STATE_W'(1);
								length_q    <= '0;
								epoch_q     <= epoch_q + 1'b1;
								out_valid_q <= 1'b1;
								if (epoch_q == '1) begin
									clr_q <= '0;
									st_q  <= ST_CLR;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == TDEPTH - 1) begin
						st_q <= ST_IDLE;
					end
				end
				ST_E0: st_q <= ST_E1;
				ST_E1: begin
					total_q <= total_q + 1'b1;
					st_q    <= ST_W_RD;
				end
				ST_W_RD: st_q <= ST_W_EV;
				ST_W_EV: begin
					if (t_rd_valid) begin
						q_q    <= t_rd_target;
						lenp_q <= len_rd;
						st_q   <= ST_CHK_RD;
					end else if (p_q == '0) begin
						st_q <= ST_DONE;
					end else begin
						p_q  <= link_rd;
						st_q <= ST_W_RD;
					end
				end
				ST_CHK_RD: st_q <= ST_CHK;
				ST_CHK: begin
					if (lenp_q + SW'(1) == len_rd) begin
						st_q <= ST_DONE;
					end else begin
						k_q     <= SW'(total_q);
						total_q <= total_q + 1'b1;
						c_q     <= '0;
						st_q    <= ST_CP_RD;
					end
				end
				ST_CP_RD: st_q <= ST_CP_WR;
				ST_CP_WR: begin
					if (32'(c_q) == ALPHABET_SIZE - 1) begin
						st_q <= ST_RED_RD;
					end else begin
						c_q  <= c_q + 1'b1;
						st_q <= ST_CP_RD;
					end
				end
				ST_RED_RD: st_q <= ST_RED_EV;
				ST_RED_EV: begin
					if (t_rd_valid && t_rd_target == q_q && p_q != '0) begin
						p_q  <= link_rd;
						st_q <= ST_RED_RD;
					end else begin
						st_q <= ST_FIN_L;
					end
				end
				ST_FIN_L: st_q <= ST_FIN_Y;
				ST_FIN_Y: st_q <= ST_DONE;
				ST_Q_RD: st_q <= ST_Q_EV;
				ST_Q_EV: begin
					qfound_q <= t_rd_valid;
					qnext_q  <= t_rd_valid ? t_rd_target : '0;
					st_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						count_q     <= sab_pkg::STATE_W'(total_q);
						if (is_query_q) begin
							next_q  <= sab_pkg::STATE_W'(qnext_q);
							found_q <= qfound_q;
						end else begin
							last_q     <= y_q;
							appended_q <= appended_q + 1'b1;
							next_q     <= sab_pkg::STATE_W'(y_q);
							length_q   <= sab_pkg::STATE_W'(appended_q + 1'b1);
						end
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign next_state  = next_q;
	assign found       = found_q;
	assign state_count = count_q;
	assign text_length = length_q;
	assign status      = status_q;

`ifndef SYNTH
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		total_q != '0) else $error("state count dropped to zero");
	a_last_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		32'(last_q) < 32'(total_q)) else $error("last state beyond state count");
	a_text_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(appended_q) <= MAX_TEXT) else $error("text length beyond capacity");
	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && out_free) |=> (out_valid_q && st_q == ST_IDLE))
		else $error("finished item gave no word");
`endif
endmodule
`default_nettype wire

// ----- hdl/sab_trans_mem.sv -----
// Transition store with epoch-tagged entries and registered read
`default_nettype none
module sab_trans_mem #(
	parameter int DEPTH = 53248,
	parameter int AW    = 16,
	parameter int SW    = 11
) (
	input  wire logic                        clk,
	input  wire logic [sab_pkg::EPOCH_W-1:0] epoch,
	input  wire logic [AW-1:0]               rd_addr,
	output logic                             rd_valid,
	output logic [SW-1:0]                    rd_target,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire logic                        wr_valid,
	input  wire logic [SW-1:0]               wr_target
);
	localparam int DW = 1 + sab_pkg::EPOCH_W + SW;

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_valid, epoch, wr_target};
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_valid  = rd_q[DW-1] && (rd_q[DW-2 -: sab_pkg::EPOCH_W] == epoch);
	assign rd_target = rd_q[SW-1:0];
endmodule
`default_nettype wire

// ----- hdl/sab_node_mem.sv -----
// Suffix link and state length stores with registered reads
`default_nettype none
module sab_node_mem #(
	parameter int DEPTH = 2048,
	parameter int SW    = 11
) (
	input  wire logic          clk,
	input  wire logic [SW-1:0] link_rd_addr,
	output logic [SW-1:0]      link_rd_data,
	input  wire logic          link_we,
	input  wire logic [SW-1:0] link_wa,
	input  wire logic [SW-1:0] link_wd,
	input  wire logic [SW-1:0] len_rd_addr,
	output logic [SW-1:0]      len_rd_data,
	input  wire logic          len_we,
	input  wire logic [SW-1:0] len_wa,
	input  wire logic [SW-1:0] len_wd
);
	logic [SW-1:0] link_mem [DEPTH];
	logic [SW-1:0] len_mem [DEPTH];
	logic [SW-1:0] link_q;
	logic [SW-1:0] len_q;
	logic          root_q;

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (len_we) begin
			len_mem[len_wa] <= len_wd;
		end
		link_q <= link_mem[link_rd_addr];
		len_q  <= len_mem[len_rd_addr];
		root_q <= (len_rd_addr == '0);
	end

	assign link_rd_data = link_q;
	assign len_rd_data  = root_q ? '0 : len_q;
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the suffix automaton builder core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ALPHA      = sab_pkg::ALPHABET_DEF;
	localparam int TEXT_MAX   = sab_pkg::MAX_TEXT_DEF;
	localparam int NODE_MAX   = 2 * TEXT_MAX;
	localparam int IDLE_LIMIT = 300000;

	typedef logic [sab_pkg::KIND_W-1:0]   kind_t;
	typedef logic [sab_pkg::SYM_W-1:0]    sym_t;
	typedef logic [sab_pkg::STATE_W-1:0]  state_t;

	typedef struct packed {
		logic [sab_pkg::STATE_W-1:0]  next_state;
		logic                         found;
		logic [sab_pkg::STATE_W-1:0]  state_count;
		logic [sab_pkg::STATE_W-1:0]  text_length;
		logic [sab_pkg::STATUS_W-1:0] status;
	} sam_word_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [sab_pkg::KIND_W-1:0]   kind;
	logic [sab_pkg::SYM_W-1:0]    symbol;
	logic [sab_pkg::STATE_W-1:0]  state_index;
	logic                         out_valid;
	logic                         out_ready;
	logic [sab_pkg::STATE_W-1:0]  next_state;
	logic                         found;
	logic [sab_pkg::STATE_W-1:0]  state_count;
	logic [sab_pkg::STATE_W-1:0]  text_length;
	logic [sab_pkg::STATUS_W-1:0] status;

	suffix_automaton_builder_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .symbol(symbol), .state_index(state_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_state(next_state), .found(found), .state_count(state_count),
		.text_length(text_length), .status(status)
	);

	state_t sam_trans [NODE_MAX*ALPHA];
	bit     sam_has   [NODE_MAX*ALPHA];
	int     sam_link  [NODE_MAX];
	int     sam_len   [NODE_MAX];
	int     sam_last;
	int     sam_total;
	int     sam_appended;

	sam_word_t pending_words [$];
	int        error_count;
	int        idle_cycles;
	int        hold_cycles;
	bit        quiet;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void sam_restart();
		for (int e = 0; e < NODE_MAX*ALPHA; e++) sam_has[e] = 1'b0;
		sam_link[0] = 0;
		sam_len[0] = 0;
		sam_last = 0;
		sam_total = 1;
		sam_appended = 0;
	endfunction

	function automatic void sam_extend(int x);
		int y, p, q, c, e;
		bit at_root;
		y = sam_total;
		p = sam_last;
		at_root = 1'b0;
		sam_total++;
		sam_len[y] = sam_len[sam_last] + 1;
		for (int a = 0; a < ALPHA; a++) sam_has[y*ALPHA+a] = 1'b0;
		forever begin
			e = p*ALPHA + x;
			if (sam_has[e]) break;
			sam_has[e] = 1'b1;
			sam_trans[e] = state_t'(y);
			if (p == 0) begin
				at_root = 1'b1;
				break;
			end
			p = sam_link[p];
		end
		if (at_root) begin
			sam_link[y] = 0;
		end else begin
			q = int'(sam_trans[p*ALPHA+x]);
			if (sam_len[p] + 1 == sam_len[q]) begin
				sam_link[y] = q;
			end else begin
				c = sam_total;
				sam_total++;
				for (int a = 0; a < ALPHA; a++) begin
					sam_trans[c*ALPHA+a] = sam_trans[q*ALPHA+a];
					sam_has[c*ALPHA+a] = sam_has[q*ALPHA+a];
				end
				sam_link[c] = sam_link[q];
				sam_len[c] = sam_len[p] + 1;
				forever begin
					e = p*ALPHA + x;
					if (!sam_has[e] || int'(sam_trans[e]) != q) break;
					sam_trans[e] = state_t'(c);
					if (p == 0) break;
					p = sam_link[p];
				end
				sam_link[q] = c;
				sam_link[y] = c;
			end
		end
		sam_last = y;
		sam_appended++;
	endfunction

	function automatic sam_word_t sam_apply(kind_t k, sym_t s, state_t idx);
		sam_word_t w;
		w = '0;
		if (k == sab_pkg::KIND_EXTEND) begin
			if (s >= ALPHA) w.status = sab_pkg::STATUS_RANGE;
			else if (sam_appended >= TEXT_MAX) w.status = sab_pkg::STATUS_FULL;
			else sam_extend(int'(s));
			w.next_state = state_t'(sam_last);
		end else if (k == sab_pkg::KIND_QUERY) begin
			if (s >= ALPHA || idx >= sam_total) begin
				w.status = sab_pkg::STATUS_RANGE;
			end else if (sam_has[idx*ALPHA+s]) begin
				w.found = 1'b1;
				w.next_state = sam_trans[idx*ALPHA+s];
			end
		end else if (k == sab_pkg::KIND_CLEAR) begin
			sam_restart();
		end
		w.state_count = state_t'(sam_total);
		w.text_length = state_t'(sam_appended);
		return w;
	endfunction

	task automatic send_word(kind_t k, sym_t s, state_t idx);
		sam_word_t w;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		symbol <= s;
		state_index <= idx;
		do @(posedge clk); while (!in_ready);
		w = sam_apply(k, s, idx);
		pending_words = {pending_words, w};
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_query_any();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) send_word(sab_pkg::KIND_QUERY, sym_t'($urandom_range(0, 31)),
			state_t'($urandom_range(0, 2047)));
		else send_word(sab_pkg::KIND_QUERY, sym_t'($urandom_range(0, ALPHA-1)),
			state_t'($urandom_range(0, sam_total)));
	endtask

	task automatic test_directed();
		send_word(sab_pkg::KIND_QUERY, 5'd0, 11'd0);
		send_word(sab_pkg::KIND_QUERY, 5'd25, 11'd1);
		send_word(sab_pkg::KIND_EXTEND, 5'd0, 11'd0);
		send_word(sab_pkg::KIND_EXTEND, 5'd1, 11'd2047);
		send_word(sab_pkg::KIND_EXTEND, 5'd0, 11'd0);
		send_word(sab_pkg::KIND_EXTEND, 5'd1, 11'd0);
		send_word(sab_pkg::KIND_EXTEND, 5'd1, 11'd0);
		send_word(sab_pkg::KIND_EXTEND, 5'd25, 11'd0);
		for (int i = 0; i < 7; i++) send_word(sab_pkg::KIND_QUERY, sym_t'(i % 2), state_t'(i));
		send_word(sab_pkg::KIND_QUERY, 5'd25, 11'd6);
		send_word(sab_pkg::KIND_EXTEND, 5'd26, 11'd0);
		send_word(sab_pkg::KIND_EXTEND, 5'd31, 11'd0);
		send_word(sab_pkg::KIND_QUERY, 5'd31, 11'd0);
		send_word(sab_pkg::KIND_QUERY, 5'd0, 11'd2047);
		send_word(sab_pkg::KIND_QUERY, 5'd0, state_t'(sam_total));
		send_word(sab_pkg::KIND_SPARE, 5'd31, 11'd2047);
		send_word(sab_pkg::KIND_CLEAR, 5'd0, 11'd0);
		send_word(sab_pkg::KIND_QUERY, 5'd0, 11'd0);
		drain();
	endtask

	task automatic test_fill();
		for (int i = 0; i < TEXT_MAX; i++) begin
			if ($urandom_range(0, 9) == 0) send_word(sab_pkg::KIND_EXTEND,
				sym_t'($urandom_range(0, ALPHA-1)), state_t'($urandom_range(0, 2047)));
			else send_word(sab_pkg::KIND_EXTEND, sym_t'($urandom_range(0, 2)),
				state_t'($urandom_range(0, 2047)));
			if ($urandom_range(0, 9) == 0) send_query_any();
		end
		send_word(sab_pkg::KIND_EXTEND, 5'd0, 11'd0);
		send_word(sab_pkg::KIND_EXTEND, 5'd30, 11'd0);
		send_word(sab_pkg::KIND_QUERY, 5'd1, state_t'(sam_total - 1));
		send_word(sab_pkg::KIND_QUERY, 5'd2, 11'd2047);
		drain();
		send_word(sab_pkg::KIND_CLEAR, 5'd0, 11'd0);
	endtask

	task automatic test_random(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55) send_word(sab_pkg::KIND_EXTEND, sym_t'($urandom_range(0, 3)),
				state_t'($urandom_range(0, 2047)));
			else if (r < 60) send_word(sab_pkg::KIND_EXTEND, sym_t'($urandom_range(0, 31)),
				state_t'($urandom_range(0, 2047)));
			else if (r < 95) send_query_any();
			else if (r < 98) send_word(sab_pkg::KIND_CLEAR, sym_t'($urandom_range(0, 31)),
				state_t'($urandom_range(0, 2047)));
			else send_word(sab_pkg::KIND_SPARE, sym_t'($urandom_range(0, 31)),
				state_t'($urandom_range(0, 2047)));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n || quiet) begin
			out_ready <= 1'b1;
			hold_cycles <= 0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			if (hold_cycles == 1) out_ready <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			hold_cycles <= $urandom_range(1, 17);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		sam_word_t want;
		if (out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word next_state=%0d", $time, next_state);
				error_count++;
			end else begin
				want = pending_words.pop_front();
				if (next_state !== want.next_state) begin
					$display("%0t: next_state expected %0d actual %0d", $time,
						want.next_state, next_state);
					error_count++;
				end
				if (found !== want.found) begin
					$display("%0t: found expected %0d actual %0d", $time, want.found, found);
					error_count++;
				end
				if (state_count !== want.state_count) begin
					$display("%0t: state_count expected %0d actual %0d", $time,
						want.state_count, state_count);
					error_count++;
				end
				if (text_length !== want.text_length) begin
					$display("%0t: text_length expected %0d actual %0d", $time,
						want.text_length, text_length);
					error_count++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		symbol = '0;
		state_index = '0;
		quiet = 1'b0;
		sam_restart();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_fill();
		test_random(200);
		drain();
		quiet = 1'b1;
		test_random(100);
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (error_count == 0 && pending_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
